@@ sv/hlc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared types, constants and arithmetic helpers of the HDR log-luma and
// chroma encoder.
// ----------------------------------------------------------------------------
package hlc_pkg;

    localparam int PIXELS     = 4;
    localparam int CHAN_W     = 33;   // signed channel, 16 fraction bits
    localparam int PIX_PROD_W = 50;   // weighted channel of one pixel
    localparam int QSUM_W     = 35;   // channel summed over the quad
    localparam int QPROD_W    = 52;   // weighted channel of the quad
    localparam int NUM_W      = 50;   // chroma dividend
    localparam int DEN_W      = 35;   // chroma divisor (quad luminance)
    localparam int Q_W        = 18;   // saturated chroma quotient
    localparam int REM_W      = DEN_W + Q_W;
    localparam int SQ_STEPS   = 11;   // log2 fraction bits
    localparam int ISQRT_STEPS = Q_W / 2;
    localparam int LUMA_LAT   = 16;   // register levels of a luma lane
    localparam int PIPE_LAT   = 33;   // register levels up to the chroma result
    localparam int ADDR_W     = 3;

    localparam logic signed [16:0] W_RED   = 17'sd13933;
    localparam logic signed [16:0] W_GREEN = 17'sd46871;
    localparam logic signed [16:0] W_BLUE  = 17'sd4732;
    localparam logic [31:0]        Y_FLOOR = 32'd7;

    localparam logic [0:0] REG_LUMA_FORMAT = 1'b0;

    typedef struct packed {
        logic [31:0] red_0;
        logic [31:0] green_0;
        logic [31:0] blue_0;
        logic [31:0] red_1;
        logic [31:0] green_1;
        logic [31:0] blue_1;
        logic [31:0] red_2;
        logic [31:0] green_2;
        logic [31:0] blue_2;
        logic [31:0] red_3;
        logic [31:0] green_3;
        logic [31:0] blue_3;
    } t_in_item;

    typedef struct packed {
        logic [15:0] luma_code_0;
        logic [15:0] luma_code_1;
        logic [15:0] luma_code_2;
        logic [15:0] luma_code_3;
        logic [7:0]  chroma_u;
        logic [7:0]  chroma_v;
    } t_out_item;

    typedef struct packed {
        logic                     nan;
        logic signed [CHAN_W-1:0] val;
    } t_chan_dec;

    typedef struct packed {
        logic                     nan;
        logic signed [CHAN_W-1:0] red;
        logic signed [CHAN_W-1:0] green;
        logic signed [CHAN_W-1:0] blue;
    } t_pix_chan;

    typedef struct packed {
        logic             kill;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_chroma_req;

    // Float32 to signed fixed point with 16 fraction bits, saturating.
    function automatic t_chan_dec f_chan_decode(input logic [31:0] bits);
        logic [7:0]  e;
        logic [31:0] m;
        logic [31:0] mag;
        t_chan_dec   d;
        e     = bits[30:23];
        m     = {8'b0, 1'b1, bits[22:0]};
        mag   = '0;
        d.nan = 1'b0;
        priority if (e == 8'hFF && bits[22:0] != 23'd0) begin
            d.nan = 1'b1;
        end else if (e >= 8'd143) begin
            mag = '1;
        end else if (e >= 8'd134) begin
            mag = m << (e - 8'd134);
        end else if (e > 8'd110) begin
            mag = m >> (8'd134 - e);
        end else begin
            mag = '0;
        end
        d.val = bits[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        return d;
    endfunction

    function automatic logic [4:0] f_lead32(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) p = 5'(i);
        end
        return p;
    endfunction

    function automatic logic [3:0] f_lead16(input logic [15:0] v);
        logic [3:0] p;
        p = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) p = 4'(i);
        end
        return p;
    endfunction

    // Half-float bits of c/65535. The quotient's binary expansion is c
    // repeated, so three copies give every bit the rounding needs.
    function automatic logic [15:0] f_half_code(input logic [15:0] c);
        logic [47:0] w;
        logic [3:0]  p;
        logic [5:0]  sh;
        logic [10:0] q;
        logic        rnd;
        logic [15:0] res;
        w   = {c, c, c};
        p   = f_lead16(c);
        sh  = 6'(p) + 6'd22;
        q   = '0;
        rnd = 1'b0;
        res = '0;
        if (c == 16'd0) begin
            res = '0;
        end else if (p >= 4'd2) begin
            q   = 11'(w >> sh);
            rnd = w[sh - 6'd1];
            res = 16'({p - 4'd2, 10'b0}) + 16'(q) + 16'(rnd);
        end else begin
            q   = 11'(w >> 24);
            rnd = w[23];
            res = 16'(q) + 16'(rnd);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ sv/hdr_log_luma_chroma_encoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hdr_log_luma_chroma_encoder_core
// Encodes a 2x2 quad of float32 RGB pixels into four log-luma codes and one
// pair of 8-bit chroma values.
// ----------------------------------------------------------------------------
// Usage:
// An item on the input channel (i_in_valid / o_in_ready) is one quad of four
// pixels, twelve float32 bit patterns. An item on the output channel
// (o_out_valid / i_out_ready) holds one 16-bit log-luma code per pixel and
// the chroma pair u, v of the whole quad. Every input item yields exactly one
// output item, in order.
// The block accepts one item per cycle while o_in_ready is high. The depth
// of the pipeline is set by the chroma path, a restoring divider with one
// quotient bit per stage followed by a square root with one result bit per
// stage. Four luma lanes run side by side and their codes wait in a delay
// line until the chroma of the same quad is ready.
// The pipeline moves as a whole. Behind it sit an output register and one
// skid register, so input is still taken while a result waits; only when
// both are full does o_in_ready fall, and it rises again in the cycle after
// the receiver takes an item.
// Reset (i_rst_n low, synchronous) empties the pipeline and both output
// registers and sets luma_format to 0. The user must write luma_format over
// the APB port at byte address 0 only when idle; the block doesn't enforce it.
// ----------------------------------------------------------------------------
module hdr_log_luma_chroma_encoder_core
    import hlc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int DLY = PIPE_LAT - LUMA_LAT;

    typedef logic [15:0] t_codes [PIXELS];

    logic                r_luma_format;
    logic [PIPE_LAT-1:0] r_vld;
    logic                pipe_en;
    logic                push, pop;

    logic [31:0]  lane_red   [PIXELS];
    logic [31:0]  lane_green [PIXELS];
    logic [31:0]  lane_blue  [PIXELS];
    t_pix_chan    lane_chan  [PIXELS];
    logic [15:0]  lane_code  [PIXELS];
    logic [15:0]  r_dly      [DLY][PIXELS];

    t_chroma_req  req_u, req_v;
    logic [7:0]   chroma_u, chroma_v;

    t_out_item    new_item;
    t_out_item    r_out, r_skd;
    logic         r_out_v, r_skd_v;

    // ---------------- configuration port ----------------
    // Register index is the word address; only luma_format exists.
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_LUMA_FORMAT) ? {31'b0, r_luma_format} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_format <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1:2] == REG_LUMA_FORMAT) begin
            r_luma_format <= pwdata[0];
        end
    end

    // ---------------- pipeline control ----------------
    // Everything moves together; the skid register absorbs the one item that
    // may leave the pipeline in the cycle the receiver stalls.
    assign pipe_en    = !r_skd_v;
    assign o_in_ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // ---------------- luma lanes ----------------
    always_comb begin
        lane_red[0]   = i_in_item.red_0;
        lane_green[0] = i_in_item.green_0;
        lane_blue[0]  = i_in_item.blue_0;
        lane_red[1]   = i_in_item.red_1;
        lane_green[1] = i_in_item.green_1;
        lane_blue[1]  = i_in_item.blue_1;
        lane_red[2]   = i_in_item.red_2;
        lane_green[2] = i_in_item.green_2;
        lane_blue[2]  = i_in_item.blue_2;
        lane_red[3]   = i_in_item.red_3;
        lane_green[3] = i_in_item.green_3;
        lane_blue[3]  = i_in_item.blue_3;
    end

    for (genvar k = 0; k < PIXELS; k++) begin : g_lane
        hlc_luma_lane u_lane (
            .i_clk         (i_clk),
            .i_en          (pipe_en),
            .i_luma_format (r_luma_format),
            .i_red         (lane_red[k]),
            .i_green       (lane_green[k]),
            .i_blue        (lane_blue[k]),
            .o_chan        (lane_chan[k]),
            .o_code        (lane_code[k])
        );
    end

    // The luma codes are ready long before the chroma; hold them back so both
    // halves of an item leave together.
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dly[0] <= lane_code;
            for (int d = 1; d < DLY; d++) begin
                r_dly[d] <= r_dly[d-1];
            end
        end
    end

    // ---------------- chroma merge and lanes ----------------
    hlc_quad_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_chan  (lane_chan),
        .o_req_u (req_u),
        .o_req_v (req_v)
    );

    hlc_chroma_lane u_chroma_u (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_req    (req_u),
        .o_chroma (chroma_u)
    );

    hlc_chroma_lane u_chroma_v (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_req    (req_v),
        .o_chroma (chroma_v)
    );

    // ---------------- output register and skid ----------------
    always_comb begin
        new_item.luma_code_0 = r_dly[DLY-1][0];
        new_item.luma_code_1 = r_dly[DLY-1][1];
        new_item.luma_code_2 = r_dly[DLY-1][2];
        new_item.luma_code_3 = r_dly[DLY-1][3];
        new_item.chroma_u    = chroma_u;
        new_item.chroma_v    = chroma_v;
    end

    assign push = pipe_en && r_vld[PIPE_LAT-1];
    assign pop  = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (pop) begin
                r_skd_v <= 1'b0;
            end
        end else if (push) begin
            if (r_out_v && !pop) begin
                r_skd_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (push) begin
            if (r_out_v && !pop) begin
                r_skd <= new_item;
            end else begin
                r_out <= new_item;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

@@ sv/hlc_luma_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_luma_lane
// One pixel: channel decode, luminance, log2 in 5.11 and the optional
// half-float conversion. Sixteen register levels.
// ----------------------------------------------------------------------------
module hlc_luma_lane
    import hlc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic        i_luma_format,
    input  wire logic [31:0] i_red,
    input  wire logic [31:0] i_green,
    input  wire logic [31:0] i_blue,
    output t_pix_chan        o_chan,
    output logic [15:0]      o_code
);

    typedef struct packed {
        logic        ok;
        logic [4:0]  p;
        logic [10:0] frac;
        logic [31:0] m;
    } t_sq_st;

    t_pix_chan r_chan, n_chan;
    t_chan_dec dec_r, dec_g, dec_b;

    logic signed [PIX_PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic                         r_nan2;
    logic signed [PIX_PROD_W-1:0] sum;
    logic [31:0]                  y_raw;
    logic [31:0]                  r_y, n_y;
    logic                         r_ok3, n_ok3;
    t_sq_st                       r_sq [SQ_STEPS+1];
    t_sq_st                       n_sq0;
    logic [15:0]                  code;
    logic [15:0]                  r_code, n_code;

    always_comb begin
        dec_r = f_chan_decode(i_red);
        dec_g = f_chan_decode(i_green);
        dec_b = f_chan_decode(i_blue);
        n_chan.nan   = dec_r.nan | dec_g.nan | dec_b.nan;
        n_chan.red   = dec_r.val;
        n_chan.green = dec_g.val;
        n_chan.blue  = dec_b.val;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan   <= n_chan;
            r_prod_r <= PIX_PROD_W'($signed(r_chan.red))   * PIX_PROD_W'(W_RED);
            r_prod_g <= PIX_PROD_W'($signed(r_chan.green)) * PIX_PROD_W'(W_GREEN);
            r_prod_b <= PIX_PROD_W'($signed(r_chan.blue))  * PIX_PROD_W'(W_BLUE);
            r_nan2   <= r_chan.nan;
        end
    end

    // Luminance is below 2^48 in magnitude, so bits 47:16 never saturate.
    always_comb begin
        sum   = r_prod_r + r_prod_g + r_prod_b;
        y_raw = sum[47:16];
        n_ok3 = !r_nan2 && (sum > 0);
        n_y   = (y_raw < Y_FLOOR) ? Y_FLOOR : y_raw;
    end

    always_comb begin
        n_sq0.ok   = r_ok3;
        n_sq0.p    = f_lead32(r_y);
        n_sq0.frac = '0;
        n_sq0.m    = r_y << (5'd31 - n_sq0.p);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y   <= n_y;
            r_ok3 <= n_ok3;
            r_sq[0] <= n_sq0;
        end
    end

    // Each squaring of the normalized mantissa yields one fraction bit.
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
        logic [63:0] mm;
        logic [32:0] m2;
        t_sq_st      n_st;
        always_comb begin
            mm        = 64'(r_sq[i].m) * 64'(r_sq[i].m);
            m2        = mm[63:31];
            n_st.ok   = r_sq[i].ok;
            n_st.p    = r_sq[i].p;
            n_st.frac = {r_sq[i].frac[9:0], m2[32]};
            n_st.m    = m2[32] ? m2[32:1] : m2[31:0];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[i+1] <= n_st;
            end
        end
    end

    always_comb begin
        code = {r_sq[SQ_STEPS].p, r_sq[SQ_STEPS].frac};
        if (!r_sq[SQ_STEPS].ok) begin
            n_code = '0;
        end else if (i_luma_format) begin
            n_code = f_half_code(code);
        end else begin
            n_code = code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_code <= n_code;
        end
    end

    assign o_chan = r_chan;
    assign o_code = r_code;

endmodule
`default_nettype wire

@@ sv/hlc_quad_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_quad_merge
// Sums the lanes' channels over the quad, forms the quad luminance and the
// two chroma dividends. Three register levels.
// ----------------------------------------------------------------------------
module hlc_quad_merge
    import hlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire t_pix_chan  i_chan [PIXELS],
    output t_chroma_req     o_req_u,
    output t_chroma_req     o_req_v
);

    logic signed [QSUM_W-1:0]  n_rs, n_gs, n_bs;
    logic                      n_nan;
    logic signed [QSUM_W-1:0]  r_rs, r_gs, r_bs;
    logic                      r_nan2, r_nan3;
    logic signed [QPROD_W-1:0] r_pr, r_pg, r_pb;
    logic signed [QPROD_W-1:0] sum;
    logic [QPROD_W-1:0]        ymag_full, mag_u, mag_v;
    logic [DEN_W-1:0]          ymag;
    logic                      ypos;
    t_chroma_req               r_req_u, r_req_v, n_req_u, n_req_v;

    always_comb begin
        n_rs  = '0;
        n_gs  = '0;
        n_bs  = '0;
        n_nan = 1'b0;
        for (int k = 0; k < PIXELS; k++) begin
            n_rs  = n_rs + QSUM_W'($signed(i_chan[k].red));
            n_gs  = n_gs + QSUM_W'($signed(i_chan[k].green));
            n_bs  = n_bs + QSUM_W'($signed(i_chan[k].blue));
            n_nan = n_nan | i_chan[k].nan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rs   <= n_rs;
            r_gs   <= n_gs;
            r_bs   <= n_bs;
            r_nan2 <= n_nan;
            r_pr   <= QPROD_W'(r_rs) * QPROD_W'(W_RED);
            r_pg   <= QPROD_W'(r_gs) * QPROD_W'(W_GREEN);
            r_pb   <= QPROD_W'(r_bs) * QPROD_W'(W_BLUE);
            r_nan3 <= r_nan2;
        end
    end

    // The blue and red products are also the chroma numerators.
    always_comb begin
        sum       = r_pr + r_pg + r_pb;
        ypos      = sum > 0;
        ymag_full = sum[QPROD_W-1] ? QPROD_W'(-sum) : QPROD_W'(sum);
        ymag      = (ymag_full[50:16] < DEN_W'(Y_FLOOR)) ? DEN_W'(Y_FLOOR) : ymag_full[50:16];
        mag_u     = r_pb[QPROD_W-1] ? QPROD_W'(-r_pb) : QPROD_W'(r_pb);
        mag_v     = r_pr[QPROD_W-1] ? QPROD_W'(-r_pr) : QPROD_W'(r_pr);

        n_req_u.kill = r_nan3 || (r_pb == '0) || (r_pb[QPROD_W-1] == ypos);
        n_req_u.num  = {mag_u[NUM_W-3:0], 2'b00};
        n_req_u.den  = ymag;
        n_req_v.kill = r_nan3 || (r_pr == '0) || (r_pr[QPROD_W-1] == ypos);
        n_req_v.num  = {mag_v[NUM_W-3:0], 2'b00};
        n_req_v.den  = ymag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req_u <= n_req_u;
            r_req_v <= n_req_v;
        end
    end

    assign o_req_u = r_req_u;
    assign o_req_v = r_req_v;

endmodule
`default_nettype wire

@@ sv/hlc_chroma_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_chroma_lane
// Pipelined restoring divider with a saturated 18-bit quotient, then a
// pipelined integer square root and rounding to 8 bits. 29 register levels.
// ----------------------------------------------------------------------------
module hlc_chroma_lane
    import hlc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire t_chroma_req i_req,
    output logic [7:0]       o_chroma
);

    typedef struct packed {
        logic             kill;
        logic             ovf;
        logic [DEN_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
    } t_div_st;

    typedef struct packed {
        logic           kill;
        logic [Q_W-1:0] x;
        logic [Q_W-1:0] res;
    } t_sqrt_st;

    t_div_st     r_div [Q_W+1];
    t_div_st     n_div0;
    t_sqrt_st    r_sqrt [ISQRT_STEPS];
    logic [9:0]  rounded;
    logic [7:0]  r_chroma, n_chroma;

    // A quotient of 2^18 or more ends in the clamp to 255 unless the request is killed.
    always_comb begin
        n_div0.kill = i_req.kill;
        n_div0.ovf  = REM_W'(i_req.num) >= {i_req.den, {Q_W{1'b0}}};
        n_div0.den  = i_req.den;
        n_div0.rem  = REM_W'(i_req.num);
        n_div0.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div[0] <= n_div0;
        end
    end

    for (genvar i = 0; i < Q_W; i++) begin : g_div
        localparam int K = Q_W - 1 - i;
        logic [REM_W-1:0] dsh;
        t_div_st          n_st;
        always_comb begin
            dsh  = REM_W'(r_div[i].den) << K;
            n_st = r_div[i];
            if (r_div[i].rem >= dsh) begin
                n_st.rem  = r_div[i].rem - dsh;
                n_st.q[K] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[i+1] <= n_st;
            end
        end
    end

    for (genvar j = 0; j < ISQRT_STEPS; j++) begin : g_sqrt
        localparam int SH = Q_W - 2 - 2 * j;
        t_sqrt_st       src;
        t_sqrt_st       n_st;
        logic [Q_W-1:0] trial;
        always_comb begin
            if (j == 0) begin
                src.kill = r_div[Q_W].kill;
                src.x    = r_div[Q_W].ovf ? '1 : r_div[Q_W].q;
                src.res  = '0;
            end else begin
                src = r_sqrt[(j == 0) ? 0 : j - 1];
            end
            trial     = src.res + (Q_W'(1) << SH);
            n_st.kill = src.kill;
            if (src.x >= trial) begin
                n_st.x   = src.x - trial;
                n_st.res = (src.res >> 1) + (Q_W'(1) << SH);
            end else begin
                n_st.x   = src.x;
                n_st.res = src.res >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sqrt[j] <= n_st;
            end
        end
    end

    always_comb begin
        rounded = 10'((r_sqrt[ISQRT_STEPS-1].res + Q_W'(1)) >> 1);
        if (r_sqrt[ISQRT_STEPS-1].kill) begin
            n_chroma = '0;
        end else if (rounded > 10'd255) begin
            n_chroma = 8'd255;
        end else begin
            n_chroma = rounded[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_chroma = r_chroma;

endmodule
`default_nettype wire

@@ sv/hlc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_props
// Port-level checks of the encoder's handshakes and output buffering.
// ----------------------------------------------------------------------------
module hlc_props
    import hlc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_out_item         o_out_item
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // Reset empties the output side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output not empty after reset");

    // Input backpressure only when a result is waiting.
    a_ready_low_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no output pending");

    // Taking a result while stalled frees the input in the next cycle.
    a_ready_recovers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && i_out_ready |=> o_in_ready)
        else $error("input stayed stalled after an item was taken");

endmodule

bind hdr_log_luma_chroma_encoder_core hlc_props u_hlc_props (.*);
`default_nettype wire
